### design/npmul_pkg.sv
// Shared types and codes for the negacyclic polynomial multiplier (mod 256).
// No dependencies; used by the top level and the testbench.
`default_nettype none
package npmul_pkg;

    localparam int ACTION_W = 2;
    localparam int IDX_W    = 8;
    localparam int COEFF_W  = 8;
    localparam int LOG_W    = 4;

    // Action codes carried on the input tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Result kind carried on the output tuser
    typedef enum logic [0:0] {
        KIND_DONE  = 1'b0,
        KIND_COEFF = 1'b1
    } kind_t;

    localparam logic [LOG_W-1:0] LOG_DEGREE_RST = 4'd8;

endpackage
`default_nettype wire

### design/npmul_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module npmul_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### design/negacyclic_poly_mul_mod256_top.sv
// Negacyclic polynomial multiplier mod (X^n + 1), coefficients mod 256.
// Loads are stored at acceptance; reads pass rd_pend_reg, then the output register.
// Throughput: one load per cycle unless stalled; input held while a read is in flight.
// Compute: one multiply-accumulate per cycle over the operand RAMs.
// Reset: rst_n asynchronous, active low; clears control state, log_degree back to 8.
// Operand and product RAMs are not cleared and hold garbage until written.
`default_nettype none
module negacyclic_poly_mul_mod256_top #(
    parameter int MAX_DEGREE = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration: log_degree
    input  wire         cfg_wr_en,
    input  wire  [3:0]  cfg_wr_data,
    // input words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [7:0] coeff_index, [15:8] a_coeff, [23:16] b_coeff
    input  wire  [1:0]  s_tuser,   // [1:0] action
    // result words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] product_coeff
    output logic [0:0]  m_tuser    // [0] kind
);

    localparam int ADDR_W = $clog2(MAX_DEGREE);
    localparam int CNT_W  = ADDR_W + 1;          // holds n itself
    localparam int EXT_W  = ADDR_W + npmul_pkg::IDX_W;
    localparam int POW_W  = 17;                  // 1 << 15 plus headroom

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // ---------------------------------------------------------------
    // Input word unpacking
    // ---------------------------------------------------------------
    npmul_pkg::action_t          in_action;
    logic [npmul_pkg::IDX_W-1:0] in_idx;
    logic [7:0]                  in_a;
    logic [7:0]                  in_b;
    logic [EXT_W-1:0]            in_idx_ext;
    logic [ADDR_W-1:0]           in_addr;
    logic                        in_range;
    logic                        in_fire;

    assign in_action  = npmul_pkg::action_t'(s_tuser);
    assign in_idx     = s_tdata[7:0];
    assign in_a       = s_tdata[15:8];
    assign in_b       = s_tdata[23:16];
    assign in_idx_ext = EXT_W'(in_idx);
    assign in_addr    = in_idx_ext[ADDR_W-1:0];
    assign in_range   = (32'(in_idx) < 32'(MAX_DEGREE));
    assign in_fire    = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                      state_reg, state_next;
    logic [npmul_pkg::LOG_W-1:0] log_degree_reg;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [ADDR_W-1:0]           k_reg, k_next;
    logic [ADDR_W-1:0]           i_reg, i_next;

    // stage 1: operand RAM data arriving
    logic                        s1_vld_reg, s1_vld_next;
    logic                        s1_neg_reg, s1_first_reg, s1_last_reg;
    logic [ADDR_W-1:0]           s1_k_reg;
    // stage 2: product ready for accumulation
    logic                        s2_vld_reg;
    logic                        s2_neg_reg, s2_first_reg, s2_last_reg;
    logic [ADDR_W-1:0]           s2_k_reg;
    logic [7:0]                  s2_prod_reg;
    logic [7:0]                  acc_reg;

    logic                        rd_pend_reg, rd_pend_next;
    logic                        rd_oob_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    npmul_pkg::kind_t            m_kind_reg, m_kind_next;
    logic [7:0]                  m_coeff_reg, m_coeff_next;

    // ---------------------------------------------------------------
    // Active length n = min(2^max(lg,1), MAX_DEGREE)
    // ---------------------------------------------------------------
    logic [npmul_pkg::LOG_W-1:0] lg_eff;
    logic [POW_W-1:0]            pow_n;
    logic [CNT_W-1:0]            n_cfg;

    assign lg_eff = (log_degree_reg == '0) ? npmul_pkg::LOG_W'(1) : log_degree_reg;
    assign pow_n  = POW_W'(1) << lg_eff;
    assign n_cfg  = (pow_n > POW_W'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE) : CNT_W'(pow_n);

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic              ab_we;
    logic [ADDR_W-1:0] b_raddr;
    logic [7:0]        a_rdata, b_rdata, p_rdata;
    logic              p_we;
    logic [7:0]        p_wdata;

    assign ab_we = in_fire && (in_action == npmul_pkg::ACT_LOAD) && in_range;

    npmul_ram #(.WIDTH(8), .DEPTH(MAX_DEGREE)) u_ram_a (
        .clk   (clk),
        .we    (ab_we),
        .waddr (in_addr),
        .wdata (in_a),
        .raddr (i_reg),
        .rdata (a_rdata)
    );

    npmul_ram #(.WIDTH(8), .DEPTH(MAX_DEGREE)) u_ram_b (
        .clk   (clk),
        .we    (ab_we),
        .waddr (in_addr),
        .wdata (in_b),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    npmul_ram #(.WIDTH(8), .DEPTH(MAX_DEGREE)) u_ram_p (
        .clk   (clk),
        .we    (p_we),
        .waddr (s2_k_reg),
        .wdata (p_wdata),
        .raddr (in_addr),
        .rdata (p_rdata)
    );

    // ---------------------------------------------------------------
    // Multiply-accumulate walk: for each k, i runs 0..n-1 and pairs
    // a[i] with b[(k-i) mod n]; wrapped terms (i > k) are subtracted.
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] j_ext;
    logic             wrap;
    logic             i_last, k_last;

    assign wrap    = (i_reg > k_reg);
    assign j_ext   = CNT_W'({1'b0, k_reg} - {1'b0, i_reg} + (wrap ? n_reg : CNT_W'(0)));
    assign b_raddr = j_ext[ADDR_W-1:0];
    assign i_last  = ({1'b0, i_reg} == CNT_W'(n_reg - CNT_W'(1)));
    assign k_last  = ({1'b0, k_reg} == CNT_W'(n_reg - CNT_W'(1)));

    logic [15:0] prod_full;
    logic [7:0]  term;
    logic [7:0]  acc_sum;

    assign prod_full = 16'(a_rdata) * 16'(b_rdata);
    assign term      = s2_neg_reg ? 8'(8'd0 - s2_prod_reg) : s2_prod_reg;
    assign acc_sum   = 8'((s2_first_reg ? 8'd0 : acc_reg) + term);
    assign p_we      = s2_vld_reg && s2_last_reg;
    assign p_wdata   = acc_sum;

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic out_free;
    logic pipe_empty;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;
    // Hold input while computing, while a read is in flight, or while a result stalls
    assign s_tready   = (state_reg == ST_IDLE) && !rd_pend_reg && out_free;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        s1_vld_next   = 1'b0;
        rd_pend_next  = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_coeff_next  = m_coeff_reg;

        // Deliver a pending product read; the output slot was free at acceptance
        if (rd_pend_reg)
        begin
            m_tvalid_next = 1'b1;
            m_kind_next   = npmul_pkg::KIND_COEFF;
            m_coeff_next  = rd_oob_reg ? 8'd0 : p_rdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_action == npmul_pkg::ACT_COMPUTE))
                begin
                    state_next = ST_RUN;
                    n_next     = n_cfg;
                    k_next     = '0;
                    i_next     = '0;
                end
                else if (in_fire && (in_action == npmul_pkg::ACT_READ))
                begin
                    rd_pend_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                s1_vld_next = 1'b1;
                if (i_last)
                begin
                    i_next = '0;
                    k_next = ADDR_W'(k_reg + ADDR_W'(1));
                    if (k_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    i_next = ADDR_W'(i_reg + ADDR_W'(1));
                end
            end
            ST_DRAIN:
            begin
                // Wait for the last write-back, then post the done word
                if (pipe_empty && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = npmul_pkg::KIND_DONE;
                    m_coeff_next  = 8'd0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            log_degree_reg <= npmul_pkg::LOG_DEGREE_RST;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s1_vld_reg;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                log_degree_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        s1_neg_reg   <= wrap;
        s1_first_reg <= (i_reg == '0);
        s1_last_reg  <= i_last;
        s1_k_reg     <= k_reg;
        s2_neg_reg   <= s1_neg_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_k_reg     <= s1_k_reg;
        s2_prod_reg  <= prod_full[7:0];
        if (s2_vld_reg)
        begin
            acc_reg <= acc_sum;
        end
        rd_oob_reg   <= !in_range;
        m_kind_reg   <= m_kind_next;
        m_coeff_reg  <= m_coeff_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_coeff_reg;

`ifndef SYNTH
    // A read may only be in flight if the output slot was free when it was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(!m_tvalid_reg || m_tready))
        else $error("read issued while output slot was occupied");

    // Product store is only written by the multiply walk
    assert property (@(posedge clk) disable iff (!rst_n)
        p_we |-> (state_reg != ST_IDLE))
        else $error("product write outside compute");

    // Input is never taken while the MAC pipeline still holds terms
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("input accepted with MAC pipeline busy");

    // Operand B index stays inside the active length during the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (j_ext < n_reg))
        else $error("operand index outside active length");

    // A done word carries a zero coefficient
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_kind_reg == npmul_pkg::KIND_DONE)) |-> (m_coeff_reg == 8'd0))
        else $error("done word with non-zero coefficient");
`endif

endmodule
`default_nettype wire

### tb/sv/negacyclic_poly_mul_mod256_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the mod-256 negacyclic polynomial multiplier: load, compute, read
// and unused-action words go in; each result word is checked against a local product predictor.
// Depends on npmul_pkg and negacyclic_poly_mul_mod256_top.
module negacyclic_poly_mul_mod256_top_tb;

    localparam int MAX_DEG = 256;

    // one input word as the sender sees it
    typedef struct {
        npmul_pkg::action_t act;
        logic [7:0]         idx;
        logic [7:0]         a;
        logic [7:0]         b;
    } op_word_t;

    // one result word as the receiver should see it
    typedef struct {
        npmul_pkg::kind_t kind;
        logic [7:0]       coeff;
    } answer_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    wire         s_tready;
    logic [23:0] s_tdata     = '0;   // [7:0] coeff_index, [15:8] a_coeff, [23:16] b_coeff
    logic [1:0]  s_tuser     = '0;   // [1:0] action
    wire         m_tvalid;
    logic        m_tready    = 1'b0;
    wire  [7:0]  m_tdata;            // [7:0] product_coeff
    wire  [0:0]  m_tuser;            // [0] kind

    // predictor state: operand copies, product copy and the degree register
    logic [7:0] a_copy [MAX_DEG];
    logic [7:0] b_copy [MAX_DEG];
    logic [7:0] d_copy [MAX_DEG];
    logic [3:0] log_degree_copy = npmul_pkg::LOG_DEGREE_RST;

    // stimulus bookkeeping: which entries may legally be used
    bit op_loaded [MAX_DEG];
    int product_span = 0;       // product entries below this index have been computed

    op_word_t words_to_send [$];
    answer_t  answers_owed [$];
    op_word_t word_on_bus;
    int       words_queued  = 0;
    int       words_taken   = 0;
    int       errors        = 0;
    int       send_idle_pct = 31;
    int       recv_idle_pct = 74;
    bit       hold_armed    = 1'b0;
    bit       hold_spent    = 1'b0;
    int       hold_left     = 0;

    negacyclic_poly_mul_mod256_top #(
        .MAX_DEGREE(MAX_DEG)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // ring length n: a log of zero counts as one, and n never passes the store depth
    function automatic int ring_length(input logic [3:0] lg);
        int n;
        n = (lg == 4'd0) ? 2 : (1 << lg);
        if (n > MAX_DEG)
            n = MAX_DEG;
        return n;
    endfunction

    // d = a * b mod (X^n + 1); terms that wrap past degree n are subtracted
    function automatic void form_product();
        int n;
        int k;
        int i;
        int acc;
        n = ring_length(log_degree_copy);
        for (k = 0; k < n; k++)
        begin
            acc = 0;
            for (i = 0; i < n; i++)
            begin
                if (i <= k)
                    acc += int'(a_copy[i]) * int'(b_copy[k - i]);
                else
                    acc -= int'(a_copy[i]) * int'(b_copy[k + n - i]);
            end
            d_copy[k] = acc[7:0];
        end
    endfunction

    // advance the predictor by one accepted word and queue what it owes
    function automatic void apply_word(input op_word_t w);
        answer_t r;
        case (w.act)
            npmul_pkg::ACT_LOAD:
            begin
                a_copy[w.idx] = w.a;
                b_copy[w.idx] = w.b;
            end
            npmul_pkg::ACT_COMPUTE:
            begin
                form_product();
                r.kind  = npmul_pkg::KIND_DONE;
                r.coeff = 8'd0;
                answers_owed.push_back(r);
            end
            npmul_pkg::ACT_READ:
            begin
                r.kind  = npmul_pkg::KIND_COEFF;
                r.coeff = d_copy[w.idx];
                answers_owed.push_back(r);
            end
            default: ;   // unused action: no state change, no answer
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: present the next pending word, drop valid when idling
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_word(word_on_bus);
                words_taken++;
            end
            // hold the current word until taken; only then pick up another
            if (!s_tvalid || s_tready)
            begin
                if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word_on_bus = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {word_on_bus.b, word_on_bus.a, word_on_bus.idx};
                    s_tuser  <= word_on_bus.act;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold-off once armed so the
    // result path backs up and the block has to stall its input
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_armed && !hold_spent)
        begin
            hold_spent = 1'b1;
            hold_left  = 400;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: compare every taken result word with the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answers_owed.size() == 0)
            begin
                $display("%0t: result word with none owed: kind %0d coeff 0x%02h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = answers_owed.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $display("%0t: kind mismatch: expected %0d actual %0d",
                             $time, want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.coeff)
                begin
                    $display("%0t: product_coeff mismatch: expected 0x%02h actual 0x%02h",
                             $time, want.coeff, m_tdata);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // coefficient value, biased towards the two extremes
    function automatic int coeff_draw();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // true once every operand entry the current ring length touches has been loaded
    function automatic bit operands_ready(input int n);
        int i;
        for (i = 0; i < n; i++)
            if (!op_loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic send(input npmul_pkg::action_t act, input int idx, input int a,
                        input int b);
        op_word_t w;
        int       n;
        w.act = act;
        w.idx = idx[7:0];
        w.a   = a[7:0];
        w.b   = b[7:0];
        n     = ring_length(log_degree_copy);
        if (act == npmul_pkg::ACT_LOAD)
            op_loaded[w.idx] = 1'b1;
        if (act == npmul_pkg::ACT_COMPUTE && n > product_span)
            product_span = n;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    // wait until every word is taken and every result is in, then let the block settle
    task automatic settle();
        do
            @(negedge clk);
        while (words_taken != words_queued || answers_owed.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    // write log_degree while the block is idle
    task automatic set_degree(input logic [3:0] lg);
        settle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lg;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        log_degree_copy = lg;
    endtask

    // load every entry 0..n-1 in shuffled order
    task automatic load_all(input int n);
        int order [$];
        int i;
        int j;
        int t;
        for (i = 0; i < n; i++)
            order.push_back(i);
        for (i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < n; i++)
            send(npmul_pkg::ACT_LOAD, order[i], coeff_draw(), coeff_draw());
    endtask

    // mostly full load / compute / read-back sequences, with noise mixed in
    task automatic random_phase(input logic [3:0] lg, input int target,
                                input int send_pct, input int recv_pct);
        int sent;
        int n;
        int extra;
        int reads;
        int i;
        set_degree(lg);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        n    = ring_length(lg);
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                load_all(n);
                extra = $urandom_range(3);
                for (i = 0; i < extra; i++)
                    send(npmul_pkg::ACT_LOAD, $urandom_range(255), coeff_draw(),
                         coeff_draw());
                send(npmul_pkg::ACT_COMPUTE, $urandom_range(255), $urandom_range(255),
                     $urandom_range(255));
                reads = $urandom_range(6, 1);
                for (i = 0; i < reads; i++)
                    send(npmul_pkg::ACT_READ, $urandom_range(n - 1), $urandom_range(255),
                         $urandom_range(255));
                sent += n + extra + 1 + reads;
            end
            else
            begin
                case ($urandom_range(3))
                    0: send(npmul_pkg::ACT_NONE, $urandom_range(255), $urandom_range(255),
                            $urandom_range(255));
                    1:
                    begin
                        send(npmul_pkg::ACT_LOAD, $urandom_range(255), coeff_draw(),
                             coeff_draw());
                        sent++;
                    end
                    2:
                        if (product_span > 0)
                        begin
                            send(npmul_pkg::ACT_READ, $urandom_range(product_span - 1),
                                 $urandom_range(255), $urandom_range(255));
                            sent++;
                        end
                    default:
                        if (operands_ready(n))
                        begin
                            send(npmul_pkg::ACT_COMPUTE, $urandom_range(255),
                                 $urandom_range(255), $urandom_range(255));
                            sent++;
                        end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        logic [3:0] degree_plan [9];
        int         p;
        int         i;
        degree_plan = '{4'd2, 4'd4, 4'd1, 4'd5, 4'd3, 4'd7, 4'd2, 4'd6, 4'd4};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // log of zero: the ring length falls back to two
        set_degree(4'd0);
        send(npmul_pkg::ACT_LOAD, 0, 8'hFF, 8'hFF);
        send(npmul_pkg::ACT_LOAD, 1, 8'h80, 8'h7F);
        send(npmul_pkg::ACT_LOAD, 255, 8'h00, 8'h00);   // beyond n: stored, not used yet
        send(npmul_pkg::ACT_NONE, 8'hFF, 8'hFF, 8'hFF); // unused action, ignored
        send(npmul_pkg::ACT_COMPUTE, 0, 0, 0);
        send(npmul_pkg::ACT_READ, 0, 0, 0);
        send(npmul_pkg::ACT_READ, 1, 8'hFF, 8'hFF);
        send(npmul_pkg::ACT_READ, 0, 0, 0);             // back-to-back reads

        set_degree(4'd1);
        send(npmul_pkg::ACT_LOAD, 1, 8'h01, 8'hFF);
        send(npmul_pkg::ACT_COMPUTE, 8'hFF, 8'hFF, 8'hFF);
        send(npmul_pkg::ACT_READ, 1, 0, 0);
        send(npmul_pkg::ACT_READ, 0, 0, 0);

        // full store length, every operand entry written
        set_degree(4'd8);
        load_all(MAX_DEG);
        send(npmul_pkg::ACT_COMPUTE, 0, 0, 0);
        send(npmul_pkg::ACT_READ, 0, 0, 0);
        send(npmul_pkg::ACT_READ, 255, 0, 0);
        send(npmul_pkg::ACT_READ, 128, 0, 0);
        for (i = 0; i < 5; i++)
            send(npmul_pkg::ACT_READ, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));

        // oversized log: length clamps to the store depth
        set_degree(4'd15);
        send(npmul_pkg::ACT_COMPUTE, 0, 0, 0);
        send(npmul_pkg::ACT_READ, 255, 0, 0);
        send(npmul_pkg::ACT_READ, 0, 0, 0);

        // short ring after a long one: entries at or above n keep their old value
        set_degree(4'd3);
        send(npmul_pkg::ACT_COMPUTE, 0, 0, 0);
        send(npmul_pkg::ACT_READ, 7, 0, 0);
        send(npmul_pkg::ACT_READ, 200, 0, 0);

        // random part: receiver-heavy idling, then sender-heavy, then none
        for (p = 0; p < 9; p++)
        begin
            if (p < 3)
                random_phase(degree_plan[p], 50, 31, 74);
            else if (p < 6)
                random_phase(degree_plan[p], 50, 74, 31);
            else
                random_phase(degree_plan[p], 50, 0, 0);
            if (p == 0)
                hold_armed = 1'b1;
        end

        settle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
design/npmul_pkg.sv
design/npmul_ram.sv
design/negacyclic_poly_mul_mod256_top.sv
tb/sv/negacyclic_poly_mul_mod256_top_tb.sv
